FILE: hdl/srlt_pkg.sv
// ---------------------------------------------------------------------------
// srlt_pkg
// Shared types and constants of the stereo RMS level trigger: register
// indexes and reset values, fixed datapath widths, queue sizing, and the
// control structs passed between the front part, the queue and the back part.
// ---------------------------------------------------------------------------
package srlt_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_GAIN      = 2'd0,
    CFG_BALANCE   = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_idx_t;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] GAIN_RST      = 16'd1024;
  localparam logic [CFG_W-1:0] BALANCE_RST   = 16'd60948;
  localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd39322;

  // Datapath widths: |sample * gain / 2048| < 2^20, so the scaled value needs
  // 21 bits and never reaches the 24-bit saturation bound.
  localparam int SAMPLE_W = 16;
  localparam int W_W      = 21;          // scaled sample
  localparam int SQ_W     = 40;          // square of a scaled sample
  localparam int MEAN_W   = 40;          // mean square is bounded by one square
  localparam int RAD_W    = MEAN_W + 2;  // radicand: 4 * mean
  localparam int ROOT_W   = RAD_W / 2;   // floor root of the radicand
  localparam int RMS_W    = 24;
  localparam int LVL_W    = 16;
  localparam int PROD_OLD_W = 2 * LVL_W;           // level * balance
  localparam int PROD_NEW_W = (CFG_W + 1) + ROOT_W; // (65536 - balance) * rms
  localparam int BLEND_W    = PROD_NEW_W + 1;

  // Block-end queue between the front and the back part
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               empty;
  } q_stat_t;

  typedef struct packed {
    logic [CFG_W-1:0] balance;
    logic [CFG_W-1:0] threshold;
  } back_cfg_t;

  // Back part sequencer
  typedef enum logic [4:0] {
    BK_IDLE  = 5'b00001,
    BK_DIV   = 5'b00010,
    BK_SQRT  = 5'b00100,
    BK_MUL   = 5'b01000,
    BK_BLEND = 5'b10000
  } back_state_t;

endpackage

FILE: hdl/srlt_queue.sv
// ---------------------------------------------------------------------------
// srlt_queue
// Short register queue that carries finished block sums from the front part
// to the back part. Push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module srlt_queue #(
  parameter int WIDTH = 60
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [WIDTH-1:0]  push_data,
  input  logic              pop,
  output logic [WIDTH-1:0]  pop_data,
  output srlt_pkg::q_stat_t stat
);
  import srlt_pkg::*;

  logic [WIDTH-1:0]   mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_pop;

  assign do_pop = pop && (cnt_r != '0);

  // Store the request at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.count = cnt_r;
  assign stat.empty = (cnt_r == '0);

endmodule

FILE: hdl/srlt_front.sv
// ---------------------------------------------------------------------------
// srlt_front
// Front part: accepts stereo frames, tracks block boundaries, scales and
// squares both samples in a two-stage pipeline, accumulates the block energy
// and pushes the sum with its frame count into the queue at block end.
// ---------------------------------------------------------------------------
module srlt_front #(
  parameter int BLOCK_FRAMES = 512,
  parameter int SUM_W        = 50,
  parameter int FCNT_W       = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [srlt_pkg::CFG_W-1:0]            gain,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [srlt_pkg::SAMPLE_W-1:0]  in_left_sample,
  input  logic signed [srlt_pkg::SAMPLE_W-1:0]  in_right_sample,
  input  logic                                  in_last_in_block,
  input  srlt_pkg::q_stat_t                     q_stat,
  output logic                                  push,
  output logic [SUM_W-1:0]                      push_sum,
  output logic [FCNT_W-1:0]                     push_frames
);
  import srlt_pkg::*;

  localparam int PROD_W = SAMPLE_W + CFG_W + 1;

  logic                     accept;
  logic [FCNT_W-1:0]        frame_cnt_r;
  logic [FCNT_W-1:0]        frames_now;
  logic                     is_last;
  logic signed [PROD_W-1:0] prod_l;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [2*W_W-1:0]  sq_l;
  logic signed [2*W_W-1:0]  sq_r;
  logic [1:0]               pending;
  logic [Q_CNT_W:0]         occupancy;
  logic [SUM_W-1:0]         acc_r;
  logic [SUM_W-1:0]         acc_sum;

  // Stage 1 registers: scaled samples
  logic                     s1_valid_r;
  logic                     s1_last_r;
  logic [FCNT_W-1:0]        s1_frames_r;
  logic signed [W_W-1:0]    s1_wl_r;
  logic signed [W_W-1:0]    s1_wr_r;

  // Stage 2 registers: squares
  logic                     s2_valid_r;
  logic                     s2_last_r;
  logic [FCNT_W-1:0]        s2_frames_r;
  logic [SQ_W-1:0]          s2_sql_r;
  logic [SQ_W-1:0]          s2_sqr_r;

  // Hold off input while the queue cannot take every block end in flight
  assign pending   = 2'(s1_valid_r && s1_last_r) + 2'(s2_valid_r && s2_last_r);
  assign occupancy = {1'b0, q_stat.count} + (Q_CNT_W+1)'(pending);
  assign in_stall  = !rst_n || (occupancy >= (Q_CNT_W+1)'(Q_DEPTH));
  assign accept    = in_valid && !in_stall;

  // Block boundary: flagged frame or a full block
  assign frames_now = frame_cnt_r + 1'b1;
  assign is_last    = in_last_in_block || (frames_now == FCNT_W'(BLOCK_FRAMES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= '0;
    end else if (accept) begin
      frame_cnt_r <= is_last ? '0 : frames_now;
    end
  end

  // Scale by gain / 2048 with floor; the product always fits 32 bits
  assign prod_l = in_left_sample * $signed({1'b0, gain});
  assign prod_r = in_right_sample * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r   <= is_last;
    s1_frames_r <= frames_now;
    s1_wl_r     <= prod_l[PROD_W-2:11];
    s1_wr_r     <= prod_r[PROD_W-2:11];
  end

  // Square both scaled samples
  assign sq_l = s1_wl_r * s1_wl_r;
  assign sq_r = s1_wr_r * s1_wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_last_r   <= s1_last_r;
    s2_frames_r <= s1_frames_r;
    s2_sql_r    <= sq_l[SQ_W-1:0];
    s2_sqr_r    <= sq_r[SQ_W-1:0];
  end

  // Accumulate; at block end hand the total to the queue and restart
  assign acc_sum = acc_r + SUM_W'(s2_sql_r) + SUM_W'(s2_sqr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (s2_valid_r) begin
      acc_r <= s2_last_r ? '0 : acc_sum;
    end
  end

  assign push        = s2_valid_r && s2_last_r;
  assign push_sum    = acc_sum;
  assign push_frames = s2_frames_r;

endmodule

FILE: hdl/srlt_back.sv
// ---------------------------------------------------------------------------
// srlt_back
// Back part: takes one block sum from the queue, divides it by the value
// count one quotient bit a cycle, takes the square root two radicand bits a
// cycle, blends the root into the smoothed level and raises the trigger.
// ---------------------------------------------------------------------------
module srlt_back #(
  parameter int SUM_W  = 50,
  parameter int FCNT_W = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srlt_pkg::back_cfg_t           cfg,
  input  srlt_pkg::q_stat_t             q_stat,
  input  logic [SUM_W-1:0]              q_sum,
  input  logic [FCNT_W-1:0]             q_frames,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srlt_pkg::LVL_W-1:0]    out_smoothed_level,
  output logic [srlt_pkg::RMS_W-1:0]    out_block_rms,
  output logic                          out_trigger
);
  import srlt_pkg::*;

  localparam int DIV_W  = FCNT_W + 1;
  localparam int STEP_W = $clog2(SUM_W);
  localparam int REM_W  = ROOT_W + 1;

  back_state_t            state_r;
  back_state_t            state_nxt;
  logic [STEP_W-1:0]      step_r;

  // Divider
  logic [SUM_W-1:0]       dvd_r;
  logic [DIV_W-1:0]       rem_r;
  logic [DIV_W-1:0]       dvs_r;
  logic [DIV_W:0]         rem_sh;
  logic [DIV_W:0]         rem_diff;
  logic                   div_ge;
  logic [SUM_W-1:0]       quo_nxt;

  // Square root
  logic [RAD_W-1:0]       rad_r;
  logic [REM_W-1:0]       sq_rem_r;
  logic [ROOT_W-1:0]      root_r;
  logic [REM_W+1:0]       sq_sh;
  logic [REM_W+1:0]       sq_trial;
  logic [REM_W+1:0]       sq_diff;
  logic                   sq_ge;

  // Blend
  logic [PROD_OLD_W-1:0]  prod_old_r;
  logic [PROD_NEW_W-1:0]  prod_new_r;
  logic [CFG_W:0]         bal_compl;
  logic [BLEND_W-1:0]     blend_sum;
  logic [LVL_W-1:0]       level_new;
  logic                   over_thr;
  logic                   out_free;
  logic [LVL_W-1:0]       level_r;
  logic                   above_r;

  logic                   out_valid_r;
  logic [LVL_W-1:0]       out_level_r;
  logic [RMS_W-1:0]       out_rms_r;
  logic                   out_trigger_r;

  // Restoring division step
  assign rem_sh   = {rem_r, dvd_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign div_ge   = (rem_sh >= {1'b0, dvs_r});
  assign quo_nxt  = {dvd_r[SUM_W-2:0], div_ge};

  // Digit-by-digit square root step
  assign sq_sh    = {sq_rem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_diff  = sq_sh - sq_trial;
  assign sq_ge    = (sq_sh >= sq_trial);

  // Blend old level with the new root and clamp to full scale
  assign bal_compl = (CFG_W+1)'(1 << CFG_W) - {1'b0, cfg.balance};
  assign blend_sum = BLEND_W'(prod_old_r) + BLEND_W'(prod_new_r);
  assign level_new = (|blend_sum[BLEND_W-1:2*LVL_W]) ? {LVL_W{1'b1}}
                                                      : blend_sum[2*LVL_W-1:LVL_W];
  assign over_thr  = (level_new > cfg.threshold);
  assign out_free  = !out_valid_r || !out_stall;

  assign pop = (state_r == BK_IDLE) && !q_stat.empty;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_r == '0) begin
          state_nxt = BK_SQRT;
        end
      end
      BK_SQRT: begin
        if (step_r == '0) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        state_nxt = BK_BLEND;
      end
      BK_BLEND: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Iteration datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        dvd_r  <= q_sum;
        rem_r  <= '0;
        dvs_r  <= {q_frames, 1'b0};
        step_r <= STEP_W'(SUM_W - 1);
      end
      BK_DIV: begin
        dvd_r <= quo_nxt;
        rem_r <= div_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        if (step_r == '0) begin
          rad_r    <= {quo_nxt[MEAN_W-1:0], 2'b00};
          sq_rem_r <= '0;
          root_r   <= '0;
          step_r   <= STEP_W'(ROOT_W - 1);
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
      BK_SQRT: begin
        rad_r    <= rad_r << 2;
        sq_rem_r <= sq_ge ? sq_diff[REM_W-1:0] : sq_sh[REM_W-1:0];
        root_r   <= {root_r[ROOT_W-2:0], sq_ge};
        step_r   <= step_r - 1'b1;
      end
      BK_MUL: begin
        prod_old_r <= level_r * cfg.balance;
        prod_new_r <= bal_compl * root_r;
      end
      default: begin
        step_r <= step_r;
      end
    endcase
  end

  // Commit level and trigger state when the result is handed over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      above_r <= 1'b0;
    end else if ((state_r == BK_BLEND) && out_free) begin
      level_r <= level_new;
      above_r <= over_thr;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == BK_BLEND) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == BK_BLEND) && out_free) begin
      out_level_r   <= level_new;
      out_rms_r     <= RMS_W'(root_r);
      out_trigger_r <= over_thr && !above_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_level = out_level_r;
  assign out_block_rms      = out_rms_r;
  assign out_trigger        = out_trigger_r;

endmodule

FILE: hdl/stereo_rms_level_trigger_top.sv
// Throughput: one stereo frame per cycle into the front part when not stalled.
// The back part divides a block sum with a bit-serial divider, then takes the
// square root; it handles one block at a time, taking the next from the queue
// only when idle, and the 4-entry queue absorbs bursts of short blocks.
// Reset (synchronous, active low) clears the control state and loads register
// defaults; datapath registers are not reset.
// ---------------------------------------------------------------------------
// stereo_rms_level_trigger_top
// Stereo RMS level meter with exponential smoothing and a one-shot trigger.
// ---------------------------------------------------------------------------
module stereo_rms_level_trigger_top #(
  parameter int BLOCK_FRAMES = 512
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [srlt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [srlt_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [srlt_pkg::SAMPLE_W-1:0]  in_left_sample,
  input  logic signed [srlt_pkg::SAMPLE_W-1:0]  in_right_sample,
  input  logic                                  in_last_in_block,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [srlt_pkg::LVL_W-1:0]            out_smoothed_level,
  output logic [srlt_pkg::RMS_W-1:0]            out_block_rms,
  output logic                                  out_trigger
);
  import srlt_pkg::*;

  localparam int FCNT_W = $clog2(BLOCK_FRAMES + 1);
  localparam int SUM_W  = SQ_W + 1 + $clog2(BLOCK_FRAMES);
  localparam int QW     = SUM_W + FCNT_W;

  logic [CFG_W-1:0]  gain_r;
  logic [CFG_W-1:0]  balance_r;
  logic [CFG_W-1:0]  threshold_r;
  back_cfg_t         back_cfg;
  q_stat_t           q_stat;
  logic              push;
  logic [SUM_W-1:0]  push_sum;
  logic [FCNT_W-1:0] push_frames;
  logic              pop;
  logic [QW-1:0]     pop_data;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RST;
      balance_r   <= BALANCE_RST;
      threshold_r <= THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN:      gain_r      <= cfg_wdata;
        CFG_BALANCE:   balance_r   <= cfg_wdata;
        CFG_THRESHOLD: threshold_r <= cfg_wdata;
        default:       gain_r      <= gain_r;
      endcase
    end
  end

  assign back_cfg.balance   = balance_r;
  assign back_cfg.threshold = threshold_r;

  srlt_front #(
    .BLOCK_FRAMES (BLOCK_FRAMES),
    .SUM_W        (SUM_W),
    .FCNT_W       (FCNT_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .gain             (gain_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_left_sample   (in_left_sample),
    .in_right_sample  (in_right_sample),
    .in_last_in_block (in_last_in_block),
    .q_stat           (q_stat),
    .push             (push),
    .push_sum         (push_sum),
    .push_frames      (push_frames)
  );

  srlt_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_sum, push_frames}),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  srlt_back #(
    .SUM_W  (SUM_W),
    .FCNT_W (FCNT_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (back_cfg),
    .q_stat             (q_stat),
    .q_sum              (pop_data[QW-1:FCNT_W]),
    .q_frames           (pop_data[FCNT_W-1:0]),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_smoothed_level (out_smoothed_level),
    .out_block_rms      (out_block_rms),
    .out_trigger        (out_trigger)
  );

endmodule

FILE: hdl/srlt_checker.sv
// ---------------------------------------------------------------------------
// srlt_checker
// Port-level checks of the stereo RMS level trigger, bound to the top level.
// ---------------------------------------------------------------------------
module srlt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_smoothed_level,
  input logic [23:0] out_block_rms,
  input logic        out_trigger
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_smoothed_level) && $stable(out_block_rms)
                              && $stable(out_trigger))
    else $error("stalled result changed");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // The root of a 42-bit radicand never needs more than 21 bits
  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_block_rms[23:21] == 3'b000))
    else $error("block rms out of range");

  // A trigger requires a level above some threshold
  a_trigger_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger |-> (out_smoothed_level != 16'd0))
    else $error("trigger with zero level");

endmodule

bind stereo_rms_level_trigger_top srlt_checker u_srlt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_smoothed_level (out_smoothed_level),
  .out_block_rms      (out_block_rms),
  .out_trigger        (out_trigger)
);

FILE: tb/sv/tb_stereo_rms_level_trigger_top.sv
// ---------------------------------------------------------------------------
// tb_stereo_rms_level_trigger_top
// Self-checking bench for the stereo RMS level meter. Stereo frames go in as
// requests with random bursts and gaps. A local model of the meter (scaling,
// energy sum, mean, root, smoothing, one-shot trigger) predicts one level
// request per block. Each returned request is checked field by field against
// the oldest prediction while the output side stalls on a pattern of its own.
// ---------------------------------------------------------------------------
module tb_stereo_rms_level_trigger_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srlt_pkg::*;

  localparam int BLOCK_FRAMES  = 512;
  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 120;   // block-end latency plus margin
  localparam int LONG_HOLD     = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int FULL_RANGE    = -1;    // amplitude code: any 16-bit sample
  localparam int PHASE_FRAMES  = 175;
  localparam int RANDOM_PHASES = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [RMS_W-1:0] rms;
    logic             trig;
  } level_res_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_left_sample = '0;
  logic signed [SAMPLE_W-1:0] in_right_sample = '0;
  logic                       in_last_in_block = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [LVL_W-1:0]           out_smoothed_level;
  logic [RMS_W-1:0]           out_block_rms;
  logic                       out_trigger;

  // Model state and register copies
  logic [CFG_W-1:0] gain_cur, balance_cur, threshold_cur;
  logic [63:0]      sum_sq;
  logic [12:0]      n_values;
  logic [LVL_W-1:0] level_now;
  logic             above_thr;
  level_res_t       level_q[$];

  // Bookkeeping
  int  cycle_count = 0;
  int  mismatches = 0;
  int  frames_sent = 0;
  int  blocks_checked = 0;
  int  triggers_seen = 0;
  int  reg_writes = 0;
  int  burst_left = 1;
  bit  bursty = 1'b1;
  int  hold_requests = 0;

  stereo_rms_level_trigger_top #(.BLOCK_FRAMES(BLOCK_FRAMES)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_left_sample     (in_left_sample),
    .in_right_sample    (in_right_sample),
    .in_last_in_block   (in_last_in_block),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_smoothed_level (out_smoothed_level),
    .out_block_rms      (out_block_rms),
    .out_trigger        (out_trigger)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ------------------------------------------------------------------ model

  // Scale by gain / 2048 with floor rounding, saturate to 24 bits
  function automatic longint scaled_value(logic signed [SAMPLE_W-1:0] s);
    longint p;
    longint w;
    p = longint'(s) * longint'({48'd0, gain_cur});
    w = p >>> 11;
    if (w > 64'sd8388607) w = 64'sd8388607;
    if (w < -64'sd8388608) w = -64'sd8388608;
    return w;
  endfunction

  // Floor square root, one result bit per step from the top
  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // Add one accepted frame; at block end queue the predicted level request
  task automatic accumulate_frame(input logic signed [SAMPLE_W-1:0] l,
                                  input logic signed [SAMPLE_W-1:0] r,
                                  input logic last);
    longint      wl, wr;
    logic [13:0] count;
    logic [63:0] mean, rms, mix;
    level_res_t  res;
    wl = scaled_value(l);
    wr = scaled_value(r);
    count = {1'b0, n_values} + 14'd2;
    sum_sq = sum_sq + 64'(wl * wl) + 64'(wr * wr);
    if (!last && count < 2 * BLOCK_FRAMES) begin
      n_values = count[12:0];
      return;
    end
    mean = sum_sq / {50'd0, count};
    rms = floor_root(mean * 64'd4);
    if (rms > 64'hFF_FFFF) rms = 64'hFF_FFFF;
    mix = (64'(level_now) * 64'(balance_cur)
           + (64'd65536 - 64'(balance_cur)) * rms) >> 16;
    if (mix > 64'd65535) mix = 64'd65535;
    level_now = mix[LVL_W-1:0];
    res.trig = 1'b0;
    if (level_now > threshold_cur) begin
      res.trig = ~above_thr;
      above_thr = 1'b1;
    end else begin
      above_thr = 1'b0;
    end
    res.level = level_now;
    res.rms = rms[RMS_W-1:0];
    level_q.insert(level_q.size(), res);
    sum_sq = '0;
    n_values = '0;
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic idle_cycles(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Offer one frame, hold it until taken, then maybe pause between bursts
  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r,
                            input logic last);
    @(negedge clk);
    in_left_sample = l;
    in_right_sample = r;
    in_last_in_block = last;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    accumulate_frame(l, r, last);
    frames_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 120);
      else burst_left = $urandom_range(1, 16);
      if (bursty) idle_cycles($urandom_range(1, 10));
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int amp);
    int v;
    if (amp == FULL_RANGE) return SAMPLE_W'($urandom);
    v = int'($urandom_range(0, 2 * amp)) - amp;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_block(input int frames, input int amp);
    for (int i = 0; i < frames; i++)
      send_frame(pick_sample(amp), pick_sample(amp), i == frames - 1);
  endtask

  // Write one register while idle and mirror it in the model
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    reg_writes++;
    case (idx)
      CFG_GAIN:      gain_cur = val;
      CFG_BALANCE:   balance_cur = val;
      CFG_THRESHOLD: threshold_cur = val;
      default: ;
    endcase
  endtask

  // Wait for every predicted request, then let the back part run dry
  task automatic wait_drained();
    idle_cycles(1);
    while (level_q.size() != 0) @(negedge clk);
  endtask

  task automatic quiesce();
    wait_drained();
    idle_cycles(SETTLE_CYCLES);
  endtask

  // --------------------------------------------------------------- receiver

  // Stall on a changing pattern; honor long hold-off requests
  always @(negedge clk) begin
    static int       hold_served = 0;
    static int       hold_left = 0;
    static int       mode_left = 0;
    static rx_mode_t rx_mode = RX_FREE;
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:  out_stall = 1'b0;
        RX_LIGHT: out_stall = ($urandom_range(0, 9) < 3);
        RX_HEAVY: out_stall = ($urandom_range(0, 9) < 7);
        default:  out_stall = ((mode_left % 4) < 2);
      endcase
    end
  end

  // ---------------------------------------------------------------- checker

  // Compare each accepted level request with the oldest prediction
  always @(posedge clk) begin
    level_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (level_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected level request: level %0d rms %0d trig %0d",
                   out_smoothed_level, out_block_rms, out_trigger);
      end else begin
        want = level_q.pop_front();
        blocks_checked++;
        if (out_trigger === 1'b1) triggers_seen++;
        if (out_smoothed_level !== want.level || out_block_rms !== want.rms ||
            out_trigger !== want.trig) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("block %0d mismatch: expected level %0d rms %0d trig %0d, got %0d %0d %0d",
                     blocks_checked, want.level, want.rms, want.trig,
                     out_smoothed_level, out_block_rms, out_trigger);
        end
      end
    end
  end

  // ------------------------------------------------------------------ tests

  // Reset values: silence, full-scale extremes, mixed polarity
  task automatic test_register_defaults();
    send_frame('0, '0, 1'b1);
    send_frame(16'sh7FFF, -16'sh8000, 1'b0);
    send_frame(-16'sh8000, 16'sh7FFF, 1'b1);
    send_frame(16'sh5555, -16'sh2AAB, 1'b1);
  endtask

  // Zero gain, gain beyond the usual range, top of the range
  task automatic test_gain_range();
    quiesce();
    write_reg(CFG_GAIN, 16'd0);
    send_frame(16'sh7FFF, -16'sh8000, 1'b0);
    send_frame(-16'sh8000, 16'sh7FFF, 1'b1);
    quiesce();
    write_reg(CFG_GAIN, 16'hFFFF);
    send_frame(-16'sh8000, -16'sh8000, 1'b1);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
    quiesce();
    write_reg(CFG_GAIN, 16'd51200);
    send_frame(-16'sh8000, 16'sh0001, 1'b1);
    send_frame(16'sh0000, -16'sh0001, 1'b1);
  endtask

  // Balance zero follows the block RMS, full balance nearly freezes the level
  task automatic test_balance_range();
    quiesce();
    write_reg(CFG_GAIN, 16'd1024);
    write_reg(CFG_BALANCE, 16'd0);
    send_frame(16'sh4000, -16'sh4000, 1'b1);
    send_frame(16'sh0100, 16'sh0100, 1'b1);
    quiesce();
    write_reg(CFG_BALANCE, 16'hFFFF);
    send_frame(16'sh7FFF, -16'sh8000, 1'b1);
    send_frame('0, '0, 1'b1);
  endtask

  // Strict compare: equal does not fire, one above fires once, then re-arms
  task automatic test_trigger_threshold();
    quiesce();
    write_reg(CFG_BALANCE, 16'd0);
    write_reg(CFG_THRESHOLD, 16'd20000);
    send_frame(16'sd20000, 16'sd20000, 1'b1);
    quiesce();
    write_reg(CFG_THRESHOLD, 16'd19999);
    send_frame(16'sd20000, 16'sd20000, 1'b1);
    send_frame(16'sd20000, 16'sd20000, 1'b1);
    quiesce();
    write_reg(CFG_THRESHOLD, 16'd0);
    send_frame('0, '0, 1'b1);
    send_frame(16'sd2, 16'sd2, 1'b1);
    quiesce();
    write_reg(CFG_GAIN, 16'd4096);
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
  endtask

  // A write to the unmapped index must leave every register alone
  task automatic test_unmapped_index();
    quiesce();
    write_reg(CFG_IDX_UNUSED, 16'd0);
    write_reg(CFG_IDX_UNUSED, 16'hFFFF);
    send_frame(16'sh1234, -16'sh4321, 1'b1);
  endtask

  // A block with no end flag closes itself at the frame limit
  task automatic test_forced_block_end();
    quiesce();
    write_reg(CFG_GAIN, 16'd1024);
    write_reg(CFG_BALANCE, 16'd32768);
    write_reg(CFG_THRESHOLD, 16'd12000);
    for (int i = 0; i < BLOCK_FRAMES; i++)
      send_frame(pick_sample(FULL_RANGE), pick_sample(FULL_RANGE), 1'b0);
    send_block(3, 20000);
  endtask

  // Hold the output long enough to back up the queue and stall the input
  task automatic test_output_backpressure();
    quiesce();
    bursty = 1'b0;
    hold_requests++;
    for (int i = 0; i < 32; i++) send_block(1, FULL_RANGE);
    bursty = 1'b1;
    wait_drained();
  endtask

  // Random settings per phase, blocks of mostly short random length
  task automatic test_random_traffic();
    int start;
    int len;
    int amp;
    int pick;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiesce();
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_GAIN, 16'd0);
        1:       write_reg(CFG_GAIN, 16'hFFFF);
        2:       write_reg(CFG_GAIN, 16'd1024);
        default: write_reg(CFG_GAIN, CFG_W'($urandom_range(0, 51200)));
      endcase
      case ($urandom_range(0, 4))
        0:       write_reg(CFG_BALANCE, 16'd0);
        1:       write_reg(CFG_BALANCE, 16'hFFFF);
        default: write_reg(CFG_BALANCE, CFG_W'($urandom));
      endcase
      case ($urandom_range(0, 4))
        0:       write_reg(CFG_THRESHOLD, 16'd0);
        1:       write_reg(CFG_THRESHOLD, 16'hFFFF);
        default: write_reg(CFG_THRESHOLD, CFG_W'($urandom));
      endcase
      start = frames_sent;
      while (frames_sent - start < PHASE_FRAMES) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) len = $urandom_range(1, 6);
        else if (pick < 19) len = $urandom_range(7, 40);
        else len = $urandom_range(41, 150);
        if (len > PHASE_FRAMES - (frames_sent - start))
          len = PHASE_FRAMES - (frames_sent - start);
        case ($urandom_range(0, 7))
          0:       amp = 0;
          1:       amp = 40;
          2:       amp = 600;
          3:       amp = 6000;
          4:       amp = 20000;
          5:       amp = 32767;
          default: amp = FULL_RANGE;
        endcase
        send_block(len, amp);
      end
    end
  endtask

  // ------------------------------------------------------------------- main

  initial begin
    gain_cur = GAIN_RST;
    balance_cur = BALANCE_RST;
    threshold_cur = THRESHOLD_RST;
    sum_sq = '0;
    n_values = '0;
    level_now = '0;
    above_thr = 1'b0;

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_register_defaults();
    test_gain_range();
    test_balance_range();
    test_trigger_threshold();
    test_unmapped_index();
    test_forced_block_end();
    test_output_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d frames, checked %0d blocks (%0d triggers), %0d register writes",
             frames_sent, blocks_checked, triggers_seen, reg_writes);
    $display("Covered gain/balance/threshold extremes, forced block end, output hold");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/srlt_pkg.sv
hdl/srlt_queue.sv
hdl/srlt_front.sv
hdl/srlt_back.sv
hdl/stereo_rms_level_trigger_top.sv
hdl/srlt_checker.sv
tb/sv/tb_stereo_rms_level_trigger_top.sv
